[rtl/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg - shared types and constants for the line substring filter
// Item structs for the text and result channels, configuration register
// indexes and the fixed field widths of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned PAT_LEN_W    = 6;
  localparam int unsigned LINE_LEN_W   = 9;
  localparam int unsigned PAT_REGS     = 4;
  localparam int unsigned PAT_BYTES    = PAT_REGS * CFG_DATA_W / BYTE_W;
  localparam int unsigned PAT_IDX_W    = $clog2(PAT_BYTES);

  // Line terminator
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHARS_LOW      = 3'd0,
    REG_CHARS_MID_LOW  = 3'd1,
    REG_CHARS_MID_HIGH = 3'd2,
    REG_CHARS_HIGH     = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } cfg_reg_t;

  // One text item
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_item_t;

  // One result item, one per finished line
  typedef struct packed {
    logic                  line_matched;
    logic [LINE_LEN_W-1:0] line_length;
    logic                  line_overflow;
  } result_item_t;

endpackage

`default_nettype wire

[rtl/line_substring_filter.sv]
// ----------------------------------------------------------------------------
// line_substring_filter - fixed-string line matcher
// Scans a byte stream and reports, for each newline-terminated line, whether
// the configured pattern occurs in it, with the line length and overflow.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   text      in         text_valid / text_stall    lsf_pkg::text_item_t
//   result    out        result_valid / result_stall lsf_pkg::result_item_t
//   config    in         cfg_wen                    cfg_index, cfg_data
//
// One text item is taken per cycle while text_stall is low; the window
// compare for all pattern positions runs in parallel in that same cycle,
// and a result shows in the result register on the following cycle.
// Reset (rst, synchronous) clears the pattern registers, the line counters
// and flags (not the window bytes) and the result valid flag.
// text_stall rises only while a finished result waits under result_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module line_substring_filter #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned MAX_LINE    = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                text_valid,
  output logic                                     text_stall,
  input  wire lsf_pkg::text_item_t                 text_item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output lsf_pkg::result_item_t                    result_item,
  input  wire logic                                cfg_wen,
  input  wire logic [lsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [lsf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_LINE + 1);
  localparam int unsigned CMP_W  = lsf_pkg::PAT_LEN_W + 1;

  // Configuration registers
  logic [lsf_pkg::CFG_DATA_W-1:0] pattern_regs [lsf_pkg::PAT_REGS];
  logic [lsf_pkg::PAT_LEN_W-1:0]  pattern_length;

  // Line state
  logic [lsf_pkg::BYTE_W-1:0] recent_window [PATTERN_MAX];
  logic [FILL_W-1:0]          window_fill;
  logic [CNT_W-1:0]           current_length;
  logic                       found_in_line;
  logic                       length_overflowed;

  // Next-value and compare signals
  logic [lsf_pkg::BYTE_W-1:0]                 window_next [PATTERN_MAX];
  logic [FILL_W-1:0]                          window_fill_next;
  logic [lsf_pkg::PAT_BYTES*lsf_pkg::BYTE_W-1:0] pattern_flat;
  logic [lsf_pkg::PAT_LEN_W-1:0]              used_len;
  logic [PATTERN_MAX-1:0]                     byte_ok;
  logic                                       window_hit;
  logic                                       text_accept;
  logic                                       is_newline;
  logic                                       line_pending;
  logic                                       line_done;
  logic                                       at_max_len;
  logic [CNT_W+lsf_pkg::LINE_LEN_W-1:0]       length_ext;

  // Take a new item unless a result is held under stall
  assign text_stall  = result_valid & result_stall;
  assign text_accept = text_valid & ~text_stall;

  assign is_newline   = (text_item.text_byte == lsf_pkg::NEWLINE_BYTE);
  assign line_pending = (current_length != '0);
  assign line_done    = text_item.end_of_text ? line_pending : is_newline;
  assign at_max_len   = (current_length == CNT_W'(MAX_LINE));

  // Pattern length clamped to the window depth
  always_comb begin
    if (pattern_length > lsf_pkg::PAT_LEN_W'(PATTERN_MAX)) begin
      used_len = lsf_pkg::PAT_LEN_W'(PATTERN_MAX);
    end else begin
      used_len = pattern_length;
    end
  end

  assign pattern_flat = {pattern_regs[3], pattern_regs[2],
                         pattern_regs[1], pattern_regs[0]};

  // Shift the new byte into the window, newest at entry 0
  always_comb begin
    window_next[0] = text_item.text_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_next[j] = recent_window[j-1];
    end
  end

  assign window_fill_next = (window_fill == FILL_W'(PATTERN_MAX)) ?
                            window_fill : window_fill + FILL_W'(1);

  // Compare every window position against its aligned pattern byte
  always_comb begin
    logic [lsf_pkg::PAT_LEN_W-1:0] pidx;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pidx = used_len - lsf_pkg::PAT_LEN_W'(j) - lsf_pkg::PAT_LEN_W'(1);
      byte_ok[j] = (lsf_pkg::PAT_LEN_W'(j) >= used_len) ||
                   (window_next[j] ==
                    pattern_flat[{pidx[lsf_pkg::PAT_IDX_W-1:0], 3'b000} +:
                                 lsf_pkg::BYTE_W]);
    end
  end

  assign window_hit = (used_len != '0) &&
                      (CMP_W'(window_fill_next) >= CMP_W'(used_len)) &&
                      (&byte_ok);

  assign length_ext = {{lsf_pkg::LINE_LEN_W{1'b0}}, current_length};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < lsf_pkg::PAT_REGS; r++) begin
        pattern_regs[r] <= '0;
      end
      pattern_length <= '0;
    end else if (cfg_wen) begin
      unique case (lsf_pkg::cfg_reg_t'(cfg_index))
        lsf_pkg::REG_CHARS_LOW:      pattern_regs[0] <= cfg_data;
        lsf_pkg::REG_CHARS_MID_LOW:  pattern_regs[1] <= cfg_data;
        lsf_pkg::REG_CHARS_MID_HIGH: pattern_regs[2] <= cfg_data;
        lsf_pkg::REG_CHARS_HIGH:     pattern_regs[3] <= cfg_data;
        lsf_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[lsf_pkg::PAT_LEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Advance the window; entries beyond the fill count are never compared
  always_ff @(posedge clk) begin
    if (text_accept && !text_item.end_of_text && !is_newline) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        recent_window[j] <= window_next[j];
      end
    end
  end

  // Update line state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill       <= '0;
      current_length    <= '0;
      found_in_line     <= 1'b0;
      length_overflowed <= 1'b0;
    end else if (text_accept) begin
      if (text_item.end_of_text || is_newline) begin
        if (line_done) begin
          window_fill       <= '0;
          current_length    <= '0;
          found_in_line     <= 1'b0;
          length_overflowed <= 1'b0;
        end
      end else begin
        window_fill <= window_fill_next;
        if (at_max_len) begin
          length_overflowed <= 1'b1;
        end else begin
          current_length <= current_length + CNT_W'(1);
        end
        if (window_hit) begin
          found_in_line <= 1'b1;
        end
      end
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (text_accept && line_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_accept && line_done) begin
      result_item.line_matched  <= found_in_line | (used_len == '0);
      result_item.line_length   <= length_ext[lsf_pkg::LINE_LEN_W-1:0];
      result_item.line_overflow <= length_overflowed;
    end
  end

endmodule

`default_nettype wire
